// ----- rtl/msd_pkg.sv -----
// ----------------------------------------------------------------------------
// msd_pkg: shared types and constants of the multi-switch debouncer
// Holds the field widths, the switch mode codes and the structs that pass
// between the front, the sample queue and the back.
// ----------------------------------------------------------------------------
package msd_pkg;

  localparam int unsigned SW_IDX_W    = 4;
  localparam int unsigned RUN_W       = 16;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [RUN_W-1:0] RANGE_RESET = 16'd20;
  localparam logic [RUN_W-1:0] RUN_MAX     = 16'hFFFF;

  typedef enum logic [1:0] {
    MODE_RELEASED = 2'd0,
    MODE_PRESSED  = 2'd1,
    MODE_BOUNCE   = 2'd2
  } mode_e;

  // A sample after classification by the front.
  typedef struct packed {
    logic                err;
    logic [SW_IDX_W-1:0] idx;
    logic                level;
  } sample_t;

  typedef struct packed {
    logic status;
    logic report_valid;
    logic reported_pressed;
  } result_t;

endpackage

// ----- rtl/msd_in_if.sv -----
// ----------------------------------------------------------------------------
// msd_in_if: sample channel
// Carries one switch index and its sampled pin level per transfer.
// ----------------------------------------------------------------------------
interface msd_in_if;
  logic                         valid;
  logic                         ready;
  logic [msd_pkg::SW_IDX_W-1:0] switch_index;
  logic                         pin_level;

  modport source (output valid, output switch_index, output pin_level, input ready);
  modport sink   (input valid, input switch_index, input pin_level, output ready);
endinterface

// ----- rtl/msd_out_if.sv -----
// ----------------------------------------------------------------------------
// msd_out_if: result channel
// Carries the status and the debounced level of one sample per transfer.
// ----------------------------------------------------------------------------
interface msd_out_if;
  logic valid;
  logic ready;
  logic status;
  logic report_valid;
  logic reported_pressed;

  modport source (output valid, output status, output report_valid,
                  output reported_pressed, input ready);
  modport sink   (input valid, input status, input report_valid,
                  input reported_pressed, output ready);
endinterface

// ----- rtl/msd_front.sv -----
// ----------------------------------------------------------------------------
// msd_front: sample intake
// Accepts samples and flags those whose switch index is out of range.
// ----------------------------------------------------------------------------
module msd_front #(
  parameter int unsigned SWITCH_COUNT = 8
) (
  msd_in_if.sink            in_if,
  output logic              smp_valid_o,
  input  logic              smp_ready_i,
  output msd_pkg::sample_t  smp_o
);
  import msd_pkg::*;

  localparam logic [SW_IDX_W:0] SwCount = SWITCH_COUNT[SW_IDX_W:0];

  assign smp_valid_o = in_if.valid;
  assign in_if.ready = smp_ready_i;

  always_comb begin
    smp_o.err   = {1'b0, in_if.switch_index} >= SwCount;
    smp_o.idx   = in_if.switch_index;
    smp_o.level = in_if.pin_level;
  end

endmodule

// ----- rtl/msd_fifo.sv -----
// ----------------------------------------------------------------------------
// msd_fifo: sample queue
// A short queue that decouples the intake from the state update.
// ----------------------------------------------------------------------------
module msd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  msd_pkg::sample_t  push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output msd_pkg::sample_t  pop_data_o
);
  import msd_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] CntFull = QUEUE_DEPTH[CntW-1:0];
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);

  sample_t         mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntFull);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/msd_back.sv -----
// ----------------------------------------------------------------------------
// msd_back: per-switch debounce update
// Updates the mode and run counts of the addressed switch and registers the
// result of each sample.
// ----------------------------------------------------------------------------
module msd_back #(
  parameter int unsigned SWITCH_COUNT = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [msd_pkg::RUN_W-1:0]   range_i,
  input  logic                        smp_valid_i,
  output logic                        smp_ready_o,
  input  msd_pkg::sample_t            smp_i,
  msd_out_if.source                   out_if
);
  import msd_pkg::*;

  localparam int unsigned IdxW = (SWITCH_COUNT > 1) ? $clog2(SWITCH_COUNT) : 1;

  mode_e            mode_q [SWITCH_COUNT];
  logic [RUN_W-1:0] hi_q   [SWITCH_COUNT];
  logic [RUN_W-1:0] lo_q   [SWITCH_COUNT];

  logic             out_valid_q;
  result_t          res_q, res_d;

  logic [IdxW-1:0]  idx;
  mode_e            mode_cur, mode_nx;
  logic [RUN_W-1:0] hi_cur, lo_cur, hi_nx, lo_nx;
  logic             take;

  assign idx         = smp_i.idx[IdxW-1:0];
  assign smp_ready_o = !out_valid_q || out_if.ready;
  assign take        = smp_valid_i && smp_ready_o;

  assign mode_cur = mode_q[idx];
  assign hi_cur   = hi_q[idx];
  assign lo_cur   = lo_q[idx];

  always_comb begin
    mode_nx = mode_cur;
    hi_nx   = hi_cur;
    lo_nx   = lo_cur;
    res_d   = '0;
    if (smp_i.err) begin
      res_d.status = 1'b1;
    end else begin
      unique case (mode_cur)
        MODE_RELEASED: begin
          if (smp_i.level) mode_nx = MODE_BOUNCE;
          res_d.report_valid = 1'b1;
        end
        MODE_PRESSED: begin
          if (!smp_i.level) mode_nx = MODE_BOUNCE;
          res_d.report_valid     = 1'b1;
          res_d.reported_pressed = 1'b1;
        end
        default: begin
          // Bounce: the run count of the sampled level grows, the other clears.
          if (smp_i.level) begin
            hi_nx = (hi_cur == RUN_MAX) ? hi_cur : hi_cur + RUN_W'(1);
            lo_nx = '0;
            if (hi_nx > range_i) begin
              mode_nx                = MODE_PRESSED;
              res_d.report_valid     = 1'b1;
              res_d.reported_pressed = 1'b1;
            end
          end else begin
            lo_nx = (lo_cur == RUN_MAX) ? lo_cur : lo_cur + RUN_W'(1);
            hi_nx = '0;
            if (lo_nx > range_i) begin
              mode_nx            = MODE_RELEASED;
              res_d.report_valid = 1'b1;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SWITCH_COUNT; i++) begin
        mode_q[i] <= MODE_RELEASED;
        hi_q[i]   <= '0;
        lo_q[i]   <= '0;
      end
    end else if (take && !smp_i.err) begin
      mode_q[idx] <= mode_nx;
      hi_q[idx]   <= hi_nx;
      lo_q[idx]   <= lo_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (smp_ready_o) begin
      out_valid_q <= smp_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

  assign out_if.valid            = out_valid_q;
  assign out_if.status           = res_q.status;
  assign out_if.report_valid     = res_q.report_valid;
  assign out_if.reported_pressed = res_q.reported_pressed;

endmodule

// ----- rtl/multi_switch_debouncer_top.sv -----
// ----------------------------------------------------------------------------
// multi_switch_debouncer_top: counter-based debouncer for several switches
// Each sample names a switch and its pin level; each sample yields one
// result with a status and, when settled, the debounced level.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload                                   Handshake
//   in_if     sink       switch_index[3:0], pin_level              valid/ready
//   out_if    source     status, report_valid, reported_pressed    valid/ready
//   cfg       write      cfg_wdata_i[15:0] (debounce range)        cfg_we_i
//
// The block sustains one transfer per cycle on each side while out_if ready
// stays high. A sample passes through the sample queue and then the output
// register of the update stage before it appears as a result. The update of a
// switch reads and writes its mode and run counts in the same cycle, so
// back-to-back samples of one switch need no forwarding. The asynchronous
// reset clears all switch modes and run counts at once and loads the debounce
// range with 20. A stall on the result side fills the two-entry queue
// before the sample side sees ready drop.
//
module multi_switch_debouncer_top #(
  parameter int unsigned SWITCH_COUNT = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [msd_pkg::RUN_W-1:0] cfg_wdata_i,
  msd_in_if.sink                    in_if,
  msd_out_if.source                 out_if
);
  import msd_pkg::*;

  // Debounce range: a run must be longer than this count to settle.
  logic [RUN_W-1:0] range_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q <= RANGE_RESET;
    end else if (cfg_we_i) begin
      range_q <= cfg_wdata_i;
    end
  end

  // Front to queue.
  logic    fr_valid, fr_ready;
  sample_t fr_smp;
  // Queue to back.
  logic    bk_valid, bk_ready;
  sample_t bk_smp;

  // The front classifies each sample as in range or not.
  msd_front #(
    .SWITCH_COUNT (SWITCH_COUNT)
  ) u_front (
    .in_if       (in_if),
    .smp_valid_o (fr_valid),
    .smp_ready_i (fr_ready),
    .smp_o       (fr_smp)
  );

  // The queue lets the intake keep going while the result side stalls.
  msd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_smp),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_data_o   (bk_smp)
  );

  // The back holds the per-switch state and registers each result.
  msd_back #(
    .SWITCH_COUNT (SWITCH_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .range_i     (range_q),
    .smp_valid_i (bk_valid),
    .smp_ready_o (bk_ready),
    .smp_i       (bk_smp),
    .out_if      (out_if)
  );

  // An error result never carries a reported level.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.status) |-> (!out_if.report_valid && !out_if.reported_pressed))
    else $error("error result carries a report");

  // A pressed level is only given together with its valid flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.reported_pressed) |-> out_if.report_valid)
    else $error("pressed level without report valid");

  // A configuration write lands in the range register on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i) |=> (!$past(rst_ni) || range_q == $past(cfg_wdata_i)))
    else $error("debounce range not updated by write");

endmodule

// ----- dv/debounce_checker.sv -----
// ----------------------------------------------------------------------------
// debounce_checker: result predictor and comparator for the debouncer
// Watches the sample and result channels and the range write port, keeps its
// own copy of every switch mode and run count, and compares each result
// transfer field by field against the oldest predicted report.
// ----------------------------------------------------------------------------
module debounce_checker
  import msd_pkg::*;
#(
  parameter int unsigned SWITCH_COUNT = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [RUN_W-1:0] cfg_wdata_i,
  msd_in_if                smp_if,
  msd_out_if               res_if,
  output int unsigned      mismatch_count_o,
  output int unsigned      reports_owed_o
);
  timeunit 1ns;
  timeprecision 1ps;

  mode_e            sw_mode  [SWITCH_COUNT];
  logic [RUN_W-1:0] high_run [SWITCH_COUNT];
  logic [RUN_W-1:0] low_run  [SWITCH_COUNT];
  logic [RUN_W-1:0] range_q;
  result_t          expected_reports[$];
  int unsigned      result_seq;

  // Applies one sample to the shadow state and returns the report it yields.
  function automatic result_t debounce_sample(input logic [SW_IDX_W-1:0] idx,
                                              input logic level);
    result_t     rep;
    int unsigned s;
    rep = '0;
    if (idx >= SWITCH_COUNT) begin
      rep.status = 1'b1;
    end else begin
      s = idx;
      case (sw_mode[s])
        MODE_RELEASED: begin
          if (level) sw_mode[s] = MODE_BOUNCE;
          rep.report_valid = 1'b1;
        end
        MODE_PRESSED: begin
          if (!level) sw_mode[s] = MODE_BOUNCE;
          rep.report_valid     = 1'b1;
          rep.reported_pressed = 1'b1;
        end
        default: begin
          // Bounce: the matching run grows (saturating), the other one clears.
          if (level) begin
            if (high_run[s] != RUN_MAX) high_run[s] = high_run[s] + 1'b1;
            low_run[s] = '0;
            if (high_run[s] > range_q) begin
              sw_mode[s]           = MODE_PRESSED;
              rep.report_valid     = 1'b1;
              rep.reported_pressed = 1'b1;
            end
          end else begin
            if (low_run[s] != RUN_MAX) low_run[s] = low_run[s] + 1'b1;
            high_run[s] = '0;
            if (low_run[s] > range_q) begin
              sw_mode[s]       = MODE_RELEASED;
              rep.report_valid = 1'b1;
            end
          end
        end
      endcase
    end
    return rep;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < SWITCH_COUNT; i++) begin
        sw_mode[i]  = MODE_RELEASED;
        high_run[i] = '0;
        low_run[i]  = '0;
      end
      range_q = RANGE_RESET;
      expected_reports.delete();
      mismatch_count_o = 0;
      reports_owed_o   = 0;
      result_seq       = 0;
    end else begin
      // Results are checked before new samples are queued, so a result can
      // never be matched against a prediction made in the same cycle.
      if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
        if (expected_reports.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected",
                                    result_seq));
        end else begin
          want = expected_reports.pop_front();
          if (res_if.status !== want.status)
            report_mismatch($sformatf("result %0d status is %b, expected %b",
                                      result_seq, res_if.status, want.status));
          if (res_if.report_valid !== want.report_valid)
            report_mismatch($sformatf("result %0d report_valid is %b, expected %b",
                                      result_seq, res_if.report_valid,
                                      want.report_valid));
          if (res_if.reported_pressed !== want.reported_pressed)
            report_mismatch($sformatf("result %0d reported_pressed is %b, expected %b",
                                      result_seq, res_if.reported_pressed,
                                      want.reported_pressed));
        end
        result_seq++;
      end
      if (smp_if.valid === 1'b1 && smp_if.ready === 1'b1)
        expected_reports.push_back(debounce_sample(smp_if.switch_index,
                                                   smp_if.pin_level));
      if (cfg_we_i === 1'b1) range_q = cfg_wdata_i;
      reports_owed_o = expected_reports.size();
    end
  end

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench top of the multi-switch debouncer
// Drives switch samples and debounce range writes, stalls the result side at
// random, and leaves prediction and comparison to the checker beside the
// block. Prints the verdict once all expected reports have been seen.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import msd_pkg::*;

  localparam int unsigned SWITCH_COUNT    = 8;
  // Long result-side hold-off that lets the sample queue fill and block input.
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  // Cycles without any transfer before the run is declared hung. The longest
  // legitimate quiet stretch is the hold-off above.
  localparam int unsigned STALL_LIMIT     = 3000;
  // Cycles to wait at the end once every expected report has been seen.
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned PHASE_ITEMS     = 220;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [RUN_W-1:0] cfg_wdata;
  int unsigned      mismatches;
  int unsigned      reports_owed;

  // When set, neither side inserts idle cycles.
  bit               no_idle      = 1'b0;
  // A request from the stimulus to the result side for one long hold-off.
  bit               hold_off_req = 1'b0;
  // The debounce range most recently written; shapes the random runs.
  logic [RUN_W-1:0] cur_range    = RANGE_RESET;
  int unsigned      stall_cycles = 0;

  msd_in_if  smp_if ();
  msd_out_if res_if ();

  multi_switch_debouncer_top #(
    .SWITCH_COUNT(SWITCH_COUNT)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_if      (smp_if),
    .out_if     (res_if)
  );

  debounce_checker #(
    .SWITCH_COUNT(SWITCH_COUNT)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .smp_if          (smp_if),
    .res_if          (res_if),
    .mismatch_count_o(mismatches),
    .reports_owed_o  (reports_owed)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offers one sample after a random gap and returns at the edge where the
  // transfer happens. Valid stays high on return, so back-to-back samples
  // keep the channel busy without a dropped cycle.
  task automatic offer_sample(input logic [SW_IDX_W-1:0] idx, input logic level);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      smp_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    smp_if.valid        <= 1'b1;
    smp_if.switch_index <= idx;
    smp_if.pin_level    <= level;
    do @(posedge clk_i); while (smp_if.ready !== 1'b1);
  endtask

  // Writes the debounce range once the block has delivered every report.
  // Every sample yields a result, so an empty prediction store means the
  // pipeline is empty too.
  task automatic load_range(input logic [RUN_W-1:0] value);
    while (reports_owed != 0) @(negedge clk_i);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    cur_range = value;
  endtask

  // Random traffic built mostly from well-formed press and release attempts:
  // a short burst of chatter on one switch followed by a steady run that is
  // usually long enough to settle at the current range, and sometimes not.
  // About one pick in ten is a lone sample on any index, out of range ones
  // included.
  task automatic drive_phase(input int unsigned n_items);
    int unsigned           sent;
    int unsigned           chatter;
    int unsigned           run_len;
    logic [SW_IDX_W-1:0]   sw;
    logic                  lvl;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        offer_sample(SW_IDX_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        sw      = SW_IDX_W'($urandom_range(0, SWITCH_COUNT - 1));
        chatter = $urandom_range(0, 4);
        repeat (chatter) offer_sample(sw, 1'($urandom_range(0, 1)));
        lvl = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 4) == 0)
          run_len = $urandom_range(1, int'(cur_range) + 1);
        else
          run_len = int'(cur_range) + 1 + $urandom_range(0, 2);
        repeat (run_len) offer_sample(sw, lvl);
        sent += chatter + run_len;
      end
    end
  endtask

  // Result side: per result a random number of cycles with ready low, or the
  // long hold-off when the stimulus asks for it.
  initial begin : result_sink
    int unsigned gap;
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        res_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
          res_if.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (res_if.valid !== 1'b1);
    end
  end

  // Watchdog: any transfer on either channel restarts the count.
  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1 || (smp_if.valid === 1'b1 && smp_if.ready === 1'b1) ||
        (res_if.valid === 1'b1 && res_if.ready === 1'b1)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [RUN_W-1:0] phase_range [6];
    phase_range = '{16'd3, 16'd0, 16'd20, 16'd1, 16'd6, 16'd2};

    rst_ni              <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    smp_if.valid        <= 1'b0;
    smp_if.switch_index <= '0;
    smp_if.pin_level    <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset range of 20: a settled released switch, a
    // press that only enters bounce, a bounce sample below threshold, and
    // both extremes of the out-of-range indexes.
    offer_sample(4'd0, 1'b0);
    offer_sample(4'd7, 1'b1);
    offer_sample(4'd8, 1'b0);
    offer_sample(4'd15, 1'b1);
    offer_sample(4'd7, 1'b0);
    smp_if.valid <= 1'b0;

    // Range 0: one sample in bounce settles the switch, so a full press and
    // release cycle takes four samples. Switch 7 is still in bounce from above.
    load_range(16'd0);
    offer_sample(4'd3, 1'b1);
    offer_sample(4'd3, 1'b1);
    offer_sample(4'd3, 1'b1);
    offer_sample(4'd3, 1'b0);
    offer_sample(4'd3, 1'b0);
    offer_sample(4'd7, 1'b0);
    offer_sample(4'd7, 1'b1);
    offer_sample(4'd7, 1'b0);
    offer_sample(4'd12, 1'b0);
    offer_sample(4'd9, 1'b1);
    smp_if.valid <= 1'b0;

    // Range 1: a low sample in bounce restarts the high run.
    load_range(16'd1);
    offer_sample(4'd5, 1'b1);
    offer_sample(4'd5, 1'b1);
    offer_sample(4'd5, 1'b0);
    offer_sample(4'd5, 1'b1);
    offer_sample(4'd5, 1'b1);
    smp_if.valid <= 1'b0;

    // Range 65535: no run count can exceed it, so a switch in bounce stays
    // there and never reports, whichever level it sees.
    load_range(16'hFFFF);
    offer_sample(4'd2, 1'b1);
    repeat (3) offer_sample(4'd2, 1'b1);
    offer_sample(4'd2, 1'b0);
    offer_sample(4'd2, 1'b1);
    smp_if.valid <= 1'b0;

    // Random phases at several ranges. The second one holds off the result
    // side for a long stretch while samples keep coming; the third runs
    // without idle cycles on either side.
    foreach (phase_range[p]) begin
      load_range(phase_range[p]);
      no_idle      = (p == 2);
      hold_off_req = (p == 1);
      drive_phase(PHASE_ITEMS);
      smp_if.valid <= 1'b0;
    end
    no_idle = 1'b0;

    while (reports_owed != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && reports_owed == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/msd_pkg.sv
rtl/msd_in_if.sv
rtl/msd_out_if.sv
rtl/msd_front.sv
rtl/msd_fifo.sv
rtl/msd_back.sv
rtl/multi_switch_debouncer_top.sv
dv/debounce_checker.sv
dv/tb.sv
